// ===== rtl/radial_coverage_histogram_assert.svh =====
// ----------------------------------------------------------------------------
// radial_coverage_histogram_assert
// Assertion macros for the radial coverage histogram.
// ----------------------------------------------------------------------------
`ifndef RADIAL_COVERAGE_HISTOGRAM_ASSERT_SVH
`define RADIAL_COVERAGE_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RCH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RCH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rch_pkg.sv =====
// ----------------------------------------------------------------------------
// rch_pkg
// Shared types and constants of the radial coverage histogram.
// ----------------------------------------------------------------------------
package rch_pkg;

  localparam int RADIUS_W = 24;
  localparam int COV_W    = 16;
  localparam int SLICE_W  = 6;
  localparam int OUT_W    = 32;
  localparam int ACT_W    = 7;
  localparam int IDX_W    = 2;
  localparam int CFG_W    = 24;
  localparam int NUM_CNT  = 5;
  localparam int STEP_CW  = 5;

  localparam logic [STEP_CW-1:0] DIV_LAST = STEP_CW'(RADIUS_W - 1);

  localparam logic [IDX_W-1:0] REG_SLICE_STEP    = 2'd0;
  localparam logic [IDX_W-1:0] REG_RADIUS_LIMIT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_ACTIVE_SLICES = 2'd2;

  // Classified voxel handed from front to back.
  typedef struct packed {
    logic [SLICE_W-1:0] slice;
    logic               hit;       // nonzero step and slice below the active slice count
    logic               in_limit;  // radius below the limit
    logic [3:0]         cov_gt;    // coverage above 0, 1, 2, 3
    logic               last;
  } rch_entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } rch_front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_UPDATE,
    B_RPT_READ,
    B_RPT_OUT
  } rch_back_state_t;

endpackage

// ===== rtl/rch_front.sv =====
// ----------------------------------------------------------------------------
// rch_front
// Takes a voxel, flags its coverage and radius, finds its slice with a
// restoring divider (one quotient bit per cycle) and pushes the word on.
// ----------------------------------------------------------------------------
module rch_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rch_pkg::COV_W-1:0]     coverage_value,
  input  logic [rch_pkg::RADIUS_W-1:0]  radius,
  input  logic                          last_point,
  input  logic [rch_pkg::RADIUS_W-1:0]  slice_step,
  input  logic [rch_pkg::RADIUS_W-1:0]  radius_limit,
  input  logic [rch_pkg::ACT_W-1:0]     nsl,
  input  logic                          q_full,
  output logic                          push,
  output rch_pkg::rch_entry_t           push_entry
);

  rch_pkg::rch_front_state_t state, state_next;

  logic [rch_pkg::RADIUS_W-1:0] dividend;
  logic [rch_pkg::RADIUS_W-1:0] rem;
  logic [rch_pkg::RADIUS_W-1:0] quot;
  logic [rch_pkg::STEP_CW-1:0]  cnt;
  logic                         step_zero;
  logic                         in_limit;
  logic [3:0]                   cov_gt;
  logic                         last;

  logic [rch_pkg::RADIUS_W:0]   trial;
  logic [rch_pkg::RADIUS_W:0]   diff;
  logic                         ge;
  logic                         accept;
  logic                         hit;

  assign accept = start && (state == rch_pkg::F_IDLE);
  assign busy   = (state != rch_pkg::F_IDLE);

  assign trial = {rem, dividend[rch_pkg::RADIUS_W-1]};
  assign ge    = (trial >= {1'b0, slice_step});
  assign diff  = trial - {1'b0, slice_step};

  assign hit = !step_zero &&
               (quot < {{(rch_pkg::RADIUS_W-rch_pkg::ACT_W){1'b0}}, nsl});

  always_comb begin
    state_next = state;
    push       = 1'b0;
    case (state)
      rch_pkg::F_IDLE: begin
        if (start) begin
          state_next = (slice_step == '0) ? rch_pkg::F_PUSH : rch_pkg::F_DIV;
        end
      end
      rch_pkg::F_DIV: begin
        if (cnt == rch_pkg::DIV_LAST) begin
          state_next = rch_pkg::F_PUSH;
        end
      end
      rch_pkg::F_PUSH: begin
        // hold the word until the queue has room
        if (!q_full) begin
          push       = 1'b1;
          state_next = rch_pkg::F_IDLE;
        end
      end
      default: state_next = rch_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rch_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dividend  <= radius;
      rem       <= '0;
      quot      <= '0;
      cnt       <= '0;
      step_zero <= (slice_step == '0);
      in_limit  <= (radius < radius_limit);
      cov_gt[0] <= (coverage_value > rch_pkg::COV_W'(0));
      cov_gt[1] <= (coverage_value > rch_pkg::COV_W'(1));
      cov_gt[2] <= (coverage_value > rch_pkg::COV_W'(2));
      cov_gt[3] <= (coverage_value > rch_pkg::COV_W'(3));
      last      <= last_point;
    end else if (state == rch_pkg::F_DIV) begin
      dividend <= {dividend[rch_pkg::RADIUS_W-2:0], 1'b0};
      rem      <= ge ? diff[rch_pkg::RADIUS_W-1:0] : trial[rch_pkg::RADIUS_W-1:0];
      quot     <= {quot[rch_pkg::RADIUS_W-2:0], ge};
      cnt      <= cnt + 1'b1;
    end
  end

  always_comb begin
    push_entry.slice    = quot[rch_pkg::SLICE_W-1:0];
    push_entry.hit      = hit;
    push_entry.in_limit = in_limit;
    push_entry.cov_gt   = cov_gt;
    push_entry.last     = last;
  end

endmodule

// ===== rtl/rch_queue.sv =====
// ----------------------------------------------------------------------------
// rch_queue
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module rch_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rch_pkg::rch_entry_t push_entry,
  output logic                full,
  output logic                valid,
  output rch_pkg::rch_entry_t head,
  input  logic                pop
);

  rch_pkg::rch_entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== rtl/rch_back.sv =====
// ----------------------------------------------------------------------------
// rch_back
// Counter store and report sequencer: a read-modify-write per word, and on
// the last word one result per active slice followed by a clear.
// ----------------------------------------------------------------------------
module rch_back #(
  parameter int MAX_SLICES  = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  rch_pkg::rch_entry_t           q_head,
  output logic                          q_pop,
  input  logic [rch_pkg::ACT_W-1:0]     nsl,
  output logic                          strobe,
  output logic [rch_pkg::SLICE_W-1:0]   slice_index,
  output logic [rch_pkg::OUT_W-1:0]     slice_total,
  output logic [rch_pkg::OUT_W-1:0]     slice_covered_once,
  output logic [rch_pkg::OUT_W-1:0]     slice_covered_twice,
  output logic [rch_pkg::OUT_W-1:0]     slice_covered_thrice,
  output logic [rch_pkg::OUT_W-1:0]     slice_covered_four,
  output logic [rch_pkg::OUT_W-1:0]     limit_points,
  output logic [rch_pkg::OUT_W-1:0]     overall_covered,
  output logic [rch_pkg::OUT_W-1:0]     overall_redundant,
  output logic                          last_result
);

  localparam int AW    = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int ROW_W = rch_pkg::NUM_CNT * COUNT_WIDTH;

  rch_pkg::rch_back_state_t state, state_next;

  logic [ROW_W-1:0]       mem [MAX_SLICES];
  logic [MAX_SLICES-1:0]  row_valid;
  logic [ROW_W-1:0]       rd_row;
  logic                   rd_vld;
  logic [AW-1:0]          rd_addr;
  logic [ROW_W-1:0]       wr_row;
  logic                   mem_we;

  rch_pkg::rch_entry_t    cur;
  logic [rch_pkg::ACT_W-1:0] k;
  logic [COUNT_WIDTH-1:0] inside_count;
  logic [COUNT_WIDTH-1:0] inside_covered_count;
  logic [COUNT_WIDTH-1:0] inside_redundant_count;

  logic                   clear_all;
  logic                   k_start;
  logic                   k_adv;
  logic                   rpt_end;
  logic [rch_pkg::NUM_CNT-1:0] inc;
  logic [COUNT_WIDTH-1:0] lane_old [rch_pkg::NUM_CNT];

  assign rpt_end = (k + 1'b1 == nsl);
  assign rd_addr = (state == rch_pkg::B_RPT_READ) ? k[AW-1:0] : cur.slice[AW-1:0];
  assign inc     = {cur.cov_gt, 1'b1};

  // saturating increment of each lane of the row whose bit in inc is set
  always_comb begin
    for (int j = 0; j < rch_pkg::NUM_CNT; j++) begin
      lane_old[j] = rd_vld ? rd_row[j*COUNT_WIDTH +: COUNT_WIDTH] : '0;
      wr_row[j*COUNT_WIDTH +: COUNT_WIDTH] =
        (inc[j] && (lane_old[j] != '1)) ? lane_old[j] + 1'b1 : lane_old[j];
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    clear_all  = 1'b0;
    k_start    = 1'b0;
    k_adv      = 1'b0;
    case (state)
      rch_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = rch_pkg::B_READ;
        end
      end
      rch_pkg::B_READ: begin
        state_next = rch_pkg::B_UPDATE;
      end
      rch_pkg::B_UPDATE: begin
        mem_we = cur.hit;
        if (!cur.last) begin
          state_next = rch_pkg::B_IDLE;
        end else if (nsl == '0) begin
          // nothing to report, clear only
          clear_all  = 1'b1;
          state_next = rch_pkg::B_IDLE;
        end else begin
          k_start    = 1'b1;
          state_next = rch_pkg::B_RPT_READ;
        end
      end
      rch_pkg::B_RPT_READ: begin
        state_next = rch_pkg::B_RPT_OUT;
      end
      rch_pkg::B_RPT_OUT: begin
        if (rpt_end) begin
          clear_all  = 1'b1;
          state_next = rch_pkg::B_IDLE;
        end else begin
          k_adv      = 1'b1;
          state_next = rch_pkg::B_RPT_READ;
        end
      end
      default: state_next = rch_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                  <= rch_pkg::B_IDLE;
      row_valid              <= '0;
      inside_count           <= '0;
      inside_covered_count   <= '0;
      inside_redundant_count <= '0;
      k                      <= '0;
    end else begin
      state <= state_next;
      if (clear_all) begin
        row_valid              <= '0;
        inside_count           <= '0;
        inside_covered_count   <= '0;
        inside_redundant_count <= '0;
      end else begin
        if (mem_we) begin
          row_valid[cur.slice[AW-1:0]] <= 1'b1;
        end
        if (q_pop && q_head.in_limit) begin
          if (inside_count != '1) begin
            inside_count <= inside_count + 1'b1;
          end
          if (q_head.cov_gt[0] && (inside_covered_count != '1)) begin
            inside_covered_count <= inside_covered_count + 1'b1;
          end
          if (q_head.cov_gt[1] && (inside_redundant_count != '1)) begin
            inside_redundant_count <= inside_redundant_count + 1'b1;
          end
        end
      end
      if (k_start) begin
        k <= '0;
      end else if (k_adv) begin
        k <= k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur.slice[AW-1:0]] <= wr_row;
    end
    rd_row <= mem[rd_addr];
    rd_vld <= row_valid[rd_addr];
  end

  assign strobe      = (state == rch_pkg::B_RPT_OUT);
  assign slice_index = k[rch_pkg::SLICE_W-1:0];
  assign last_result = strobe && rpt_end;

  assign slice_total          = rch_pkg::OUT_W'(lane_old[0]);
  assign slice_covered_once   = rch_pkg::OUT_W'(lane_old[1]);
  assign slice_covered_twice  = rch_pkg::OUT_W'(lane_old[2]);
  assign slice_covered_thrice = rch_pkg::OUT_W'(lane_old[3]);
  assign slice_covered_four   = rch_pkg::OUT_W'(lane_old[4]);
  assign limit_points         = rch_pkg::OUT_W'(inside_count);
  assign overall_covered      = rch_pkg::OUT_W'(inside_covered_count);
  assign overall_redundant    = rch_pkg::OUT_W'(inside_redundant_count);

endmodule

// ===== rtl/radial_coverage_histogram.sv =====
// ----------------------------------------------------------------------------
// radial_coverage_histogram
// Per-slice and overall coverage counts of a voxel stream, reported after a last voxel.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive coverage_value, radius and last_point with start high; the
//   voxel is taken at the edge where start is high and busy is low.
//   Each voxel goes through the front as accept, 24 divider steps for the
//   slice number, then hand-off, and busy stays high after accept until the
//   hand-off, so a new voxel waits; the divider makes one quotient bit per
//   cycle. A zero slice_step skips the divider. The hand-off waits while
//   the two-word queue is full, so busy stretches while the back end is
//   reporting. Back: each voxel is popped, then its counter row is read,
//   modified and written (IDLE, READ, UPDATE). A voxel with last_point set
//   then gives one result per active slice, slice 0 first, each presented
//   after its memory read, last_result on the final one; all counters then clear at once.
//   Results: strobe marks each result for exactly one cycle; the receiver
//   cannot stall, so take every word as it comes.
//   Configuration: wr_en, wr_index, wr_data; write only while the block is
//   idle. Index 0 slice_step, 1 radius_limit, 2 active_slices.
//   Reset (rst, synchronous): counters cleared, registers to their defaults,
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "radial_coverage_histogram_assert.svh"

module radial_coverage_histogram #(
  parameter int MAX_SLICES  = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rch_pkg::COV_W-1:0]     coverage_value,
  input  logic [rch_pkg::RADIUS_W-1:0]  radius,
  input  logic                          last_point,
  input  logic                          wr_en,
  input  logic [rch_pkg::IDX_W-1:0]     wr_index,
  input  logic [rch_pkg::CFG_W-1:0]     wr_data,
  output logic                          strobe,
  output logic [rch_pkg::SLICE_W-1:0]   slice_index,
  output logic [rch_pkg::OUT_W-1:0]     slice_total,
  output logic [rch_pkg::OUT_W-1:0]     slice_covered_once,
  output logic [rch_pkg::OUT_W-1:0]     slice_covered_twice,
  output logic [rch_pkg::OUT_W-1:0]     slice_covered_thrice,
  output logic [rch_pkg::OUT_W-1:0]     slice_covered_four,
  output logic [rch_pkg::OUT_W-1:0]     limit_points,
  output logic [rch_pkg::OUT_W-1:0]     overall_covered,
  output logic [rch_pkg::OUT_W-1:0]     overall_redundant,
  output logic                          last_result
);

  localparam logic [rch_pkg::ACT_W-1:0] MAX_SL = rch_pkg::ACT_W'(MAX_SLICES);

  logic [rch_pkg::RADIUS_W-1:0] slice_step;
  logic [rch_pkg::RADIUS_W-1:0] radius_limit;
  logic [rch_pkg::ACT_W-1:0]    active_slices;
  logic [rch_pkg::ACT_W-1:0]    nsl;

  logic                q_full;
  logic                q_push;
  logic                q_valid;
  logic                q_pop;
  rch_pkg::rch_entry_t push_entry;
  rch_pkg::rch_entry_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_step    <= rch_pkg::RADIUS_W'(65536);
      radius_limit  <= rch_pkg::RADIUS_W'(65536);
      active_slices <= rch_pkg::ACT_W'(64);
    end else if (wr_en) begin
      case (wr_index)
        rch_pkg::REG_SLICE_STEP:    slice_step    <= wr_data;
        rch_pkg::REG_RADIUS_LIMIT:  radius_limit  <= wr_data;
        rch_pkg::REG_ACTIVE_SLICES: active_slices <= wr_data[rch_pkg::ACT_W-1:0];
        default: ;
      endcase
    end
  end

  assign nsl = (active_slices > MAX_SL) ? MAX_SL : active_slices;

  rch_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .coverage_value (coverage_value),
    .radius         (radius),
    .last_point     (last_point),
    .slice_step     (slice_step),
    .radius_limit   (radius_limit),
    .nsl            (nsl),
    .q_full         (q_full),
    .push           (q_push),
    .push_entry     (push_entry)
  );

  rch_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .valid      (q_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  rch_back #(
    .MAX_SLICES  (MAX_SLICES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk                  (clk),
    .rst                  (rst),
    .q_valid              (q_valid),
    .q_head               (q_head),
    .q_pop                (q_pop),
    .nsl                  (nsl),
    .strobe               (strobe),
    .slice_index          (slice_index),
    .slice_total          (slice_total),
    .slice_covered_once   (slice_covered_once),
    .slice_covered_twice  (slice_covered_twice),
    .slice_covered_thrice (slice_covered_thrice),
    .slice_covered_four   (slice_covered_four),
    .limit_points         (limit_points),
    .overall_covered      (overall_covered),
    .overall_redundant    (overall_redundant),
    .last_result          (last_result)
  );

  `RCH_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted voxel did not raise busy")
  `RCH_ASSERT_SAME(a_push_room, clk, rst, q_push, !q_full, "push into a full queue")
  `RCH_ASSERT_NEXT(a_result_gap, clk, rst, strobe, !strobe, "results on adjacent cycles")
  `RCH_ASSERT_SAME(a_slice_range, clk, rst, strobe, rch_pkg::ACT_W'(slice_index) < nsl, "slice index beyond active slices")

endmodule

// ===== bench/histogram_checker.sv =====
// ----------------------------------------------------------------------------
// histogram_checker
// Watches the voxel, register and result channels of the radial coverage
// histogram. Keeps its own copy of the slice and overall counters, builds the
// expected report words when a last voxel is taken, and compares every result
// word field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module histogram_checker
  import rch_pkg::*;
#(
  parameter int MAX_SLICES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [COV_W-1:0]    coverage_value,
  input  logic [RADIUS_W-1:0] radius,
  input  logic                last_point,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_index,
  input  logic [CFG_W-1:0]    wr_data,
  input  logic                strobe,
  input  logic [SLICE_W-1:0]  slice_index,
  input  logic [OUT_W-1:0]    slice_total,
  input  logic [OUT_W-1:0]    slice_covered_once,
  input  logic [OUT_W-1:0]    slice_covered_twice,
  input  logic [OUT_W-1:0]    slice_covered_thrice,
  input  logic [OUT_W-1:0]    slice_covered_four,
  input  logic [OUT_W-1:0]    limit_points,
  input  logic [OUT_W-1:0]    overall_covered,
  input  logic [OUT_W-1:0]    overall_redundant,
  input  logic                last_result,
  output int                  mismatches,
  output int                  outstanding
);

  localparam logic [OUT_W-1:0] COUNT_FULL = '1;

  typedef struct packed {
    logic [SLICE_W-1:0] slice;
    logic [OUT_W-1:0]   total;
    logic [OUT_W-1:0]   over_zero;
    logic [OUT_W-1:0]   over_one;
    logic [OUT_W-1:0]   over_two;
    logic [OUT_W-1:0]   over_three;
    logic [OUT_W-1:0]   points;
    logic [OUT_W-1:0]   covered;
    logic [OUT_W-1:0]   redundant;
    logic               last;
  } slice_report_t;

  logic [RADIUS_W-1:0] step_reg;
  logic [RADIUS_W-1:0] limit_reg;
  logic [ACT_W-1:0]    slices_reg;

  // Row 0 counts every voxel of a slice, row j those with coverage of at least j.
  logic [OUT_W-1:0]    slice_counts [NUM_CNT][MAX_SLICES];
  logic [OUT_W-1:0]    points_in;
  logic [OUT_W-1:0]    covered_in;
  logic [OUT_W-1:0]    redundant_in;

  slice_report_t       report_queue [$];

  function automatic logic [OUT_W-1:0] bumped(input logic [OUT_W-1:0] c);
    return (c == COUNT_FULL) ? c : c + 1'b1;
  endfunction

  task automatic clear_counts();
    for (int j = 0; j < NUM_CNT; j++)
      for (int k = 0; k < MAX_SLICES; k++)
        slice_counts[j][k] = '0;
    points_in    = '0;
    covered_in   = '0;
    redundant_in = '0;
  endtask

  task automatic tally_voxel(input logic [COV_W-1:0] cov, input logic [RADIUS_W-1:0] rad,
                             input logic last);
    int                  nsl;
    logic [RADIUS_W-1:0] slice;
    slice_report_t       rpt;
    nsl = (slices_reg > MAX_SLICES) ? MAX_SLICES : int'(slices_reg);
    if (rad < limit_reg) begin
      points_in = bumped(points_in);
      if (cov > 0) covered_in = bumped(covered_in);
      if (cov > 1) redundant_in = bumped(redundant_in);
    end
    // A zero step puts the voxel in no slice at all.
    if (step_reg != '0) begin
      slice = rad / step_reg;
      if (slice < nsl)
        for (int j = 0; j < NUM_CNT; j++)
          if (cov >= j) slice_counts[j][slice] = bumped(slice_counts[j][slice]);
    end
    if (last) begin
      for (int k = 0; k < nsl; k++) begin
        rpt.slice      = SLICE_W'(k);
        rpt.total      = slice_counts[0][k];
        rpt.over_zero  = slice_counts[1][k];
        rpt.over_one   = slice_counts[2][k];
        rpt.over_two   = slice_counts[3][k];
        rpt.over_three = slice_counts[4][k];
        rpt.points     = points_in;
        rpt.covered    = covered_in;
        rpt.redundant  = redundant_in;
        rpt.last       = (k == nsl - 1);
        report_queue.push_back(rpt);
      end
      clear_counts();
    end
  endtask

  task automatic check_field(input string label, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    slice_report_t want;
    if (rst) begin
      step_reg   = 24'd65536;
      limit_reg  = 24'd65536;
      slices_reg = 7'd64;
      clear_counts();
      report_queue.delete();
      outstanding <= 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_SLICE_STEP:    step_reg   = wr_data[RADIUS_W-1:0];
          REG_RADIUS_LIMIT:  limit_reg  = wr_data[RADIUS_W-1:0];
          REG_ACTIVE_SLICES: slices_reg = wr_data[ACT_W-1:0];
          default: ;
        endcase
      end
      if ($isunknown(strobe)) begin
        $display("%0t: strobe expected 0 or 1, got %b", $time, strobe);
        mismatches++;
      end else if (strobe) begin
        if (report_queue.size() == 0) begin
          $display("%0t: result word expected none, got slice %0d", $time, slice_index);
          mismatches++;
        end else begin
          want = report_queue.pop_front();
          check_field("slice_index", OUT_W'(want.slice), OUT_W'(slice_index));
          check_field("slice_total", want.total, slice_total);
          check_field("slice_covered_once", want.over_zero, slice_covered_once);
          check_field("slice_covered_twice", want.over_one, slice_covered_twice);
          check_field("slice_covered_thrice", want.over_two, slice_covered_thrice);
          check_field("slice_covered_four", want.over_three, slice_covered_four);
          check_field("limit_points", want.points, limit_points);
          check_field("overall_covered", want.covered, overall_covered);
          check_field("overall_redundant", want.redundant, overall_redundant);
          check_field("last_result", OUT_W'(want.last), OUT_W'(last_result));
        end
      end
      if (start && !busy) tally_voxel(coverage_value, radius, last_point);
      outstanding <= report_queue.size();
    end
  end

endmodule

// ===== bench/tb_radial_coverage_histogram.sv =====
// ----------------------------------------------------------------------------
// tb_radial_coverage_histogram
// Drives voxel words and register settings into the radial coverage histogram:
// a directed pass over field extremes, slice edges and the odd settings, then
// random voxel bursts, most ending in a last voxel, under random settings. Checking is
// left to histogram_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_radial_coverage_histogram;
  import rch_pkg::*;

  // No register sits at this index; writes to it must be dropped.
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 80;

  logic                clk;
  logic                rst            = 1'b1;
  logic                start          = 1'b0;
  logic [COV_W-1:0]    coverage_value = '0;
  logic [RADIUS_W-1:0] radius         = '0;
  logic                last_point     = 1'b0;
  logic                wr_en          = 1'b0;
  logic [IDX_W-1:0]    wr_index       = '0;
  logic [CFG_W-1:0]    wr_data        = '0;

  logic                busy;
  logic                strobe;
  logic [SLICE_W-1:0]  slice_index;
  logic [OUT_W-1:0]    slice_total;
  logic [OUT_W-1:0]    slice_covered_once;
  logic [OUT_W-1:0]    slice_covered_twice;
  logic [OUT_W-1:0]    slice_covered_thrice;
  logic [OUT_W-1:0]    slice_covered_four;
  logic [OUT_W-1:0]    limit_points;
  logic [OUT_W-1:0]    overall_covered;
  logic [OUT_W-1:0]    overall_redundant;
  logic                last_result;

  int mismatches;
  int outstanding;
  int cycles = 0;
  int sent   = 0;
  bit steady = 1'b0;

  // Current setting, used only to aim radii at the slices and at the limit edge.
  logic [RADIUS_W-1:0] cur_step   = 24'd65536;
  logic [RADIUS_W-1:0] cur_limit  = 24'd65536;
  int                  cur_slices = 64;

  radial_coverage_histogram dut (.*);

  histogram_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  function automatic logic [COV_W-1:0] pick_cov();
    if ($urandom_range(7, 0) < 6) return COV_W'($urandom_range(5, 0));
    return COV_W'($urandom);
  endfunction

  function automatic logic [RADIUS_W-1:0] pick_radius();
    longint span;
    int     r;
    r = $urandom_range(7, 0);
    span = longint'(cur_step) * (cur_slices + 1);
    if (span == 0 || span > 64'hFFFFFF) span = 64'hFFFFFF;
    if (r < 6) return RADIUS_W'($urandom_range(int'(span), 0));
    if (r == 6) return RADIUS_W'(cur_limit + $urandom_range(2, 0) - 1);
    return RADIUS_W'($urandom);
  endfunction

  task automatic send_voxel(input logic [COV_W-1:0] cov, input logic [RADIUS_W-1:0] rad,
                            input logic last);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    coverage_value <= cov;
    radius         <= rad;
    last_point     <= last;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Hold off until every expected word is in and the back end has drained.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] step, input logic [CFG_W-1:0] limit,
                               input logic [CFG_W-1:0] slices);
    settle();
    write_reg(REG_SLICE_STEP, step);
    write_reg(REG_RADIUS_LIMIT, limit);
    write_reg(REG_ACTIVE_SLICES, slices);
    write_reg(REG_SPARE, CFG_W'($urandom));
    wr_en      <= 1'b0;
    cur_step   = step;
    cur_limit  = limit;
    cur_slices = (slices[ACT_W-1:0] > 64) ? 64 : int'(slices[ACT_W-1:0]);
  endtask

  initial begin
    int                  target;
    int                  r;
    int                  burst_len;
    bit                  broken;
    logic [CFG_W-1:0]    step;
    logic [CFG_W-1:0]    slices;
    logic [CFG_W-1:0]    limit;
    longint              span;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Reset setting: limit edge, last slice, one past the last slice, widest fields.
    send_voxel(16'd0, 24'd0, 1'b0);
    send_voxel(16'd1, 24'h00FFFF, 1'b0);
    send_voxel(16'd2, 24'h010000, 1'b0);
    send_voxel(16'd3, 24'h3FFFFF, 1'b0);
    send_voxel(16'd4, 24'h400000, 1'b0);
    send_voxel(16'hFFFF, 24'hFFFFFF, 1'b1);

    // Smallest step and limit, one slice; junk above the slice count bits.
    apply_setting(24'd1, 24'd0, 24'hABCD81);
    send_voxel(16'd5, 24'd0, 1'b0);
    send_voxel(16'd0, 24'd1, 1'b0);
    send_voxel(16'hFFFF, 24'd0, 1'b1);

    // Largest step and limit; slice count above the maximum acts as the maximum.
    apply_setting(24'hFFFFFF, 24'hFFFFFF, 24'd127);
    send_voxel(16'd2, 24'hFFFFFE, 1'b0);
    send_voxel(16'd1, 24'hFFFFFF, 1'b1);

    // Zero step: overall counts only.
    apply_setting(24'd0, 24'h020000, 24'd3);
    send_voxel(16'd4, 24'd5, 1'b0);
    send_voxel(16'd1, 24'h030000, 1'b1);

    // Zero slices: no words, but the counters still clear.
    apply_setting(24'h008000, 24'h010000, 24'd0);
    send_voxel(16'd3, 24'd0, 1'b0);
    send_voxel(16'd0, 24'd0, 1'b1);
    apply_setting(24'h008000, 24'h010000, 24'd2);
    send_voxel(16'd1, 24'h008000, 1'b1);

    target = sent + RANDOM_ITEMS;
    while (sent < target) begin
      r = $urandom_range(7, 0);
      case (r)
        0:       step = CFG_W'($urandom_range(64, 1));
        5:       step = '0;
        6:       step = CFG_W'($urandom);
        7:       step = CFG_W'($urandom_range(24'h010000, 1));
        default: step = CFG_W'($urandom_range(24'h020000, 24'h000100));
      endcase
      r = $urandom_range(7, 0);
      if (r < 5) slices = CFG_W'($urandom_range(16, 1));
      else if (r == 5) slices = 24'd64;
      else if (r == 6) slices = CFG_W'($urandom_range(127, 65));
      else slices = CFG_W'($urandom_range(63, 0));
      span = longint'(step) * (slices[ACT_W-1:0] + 1);
      if (span == 0 || span > 64'hFFFFFF) span = 64'hFFFFFF;
      limit = CFG_W'(($urandom_range(7, 0) < 6) ? $urandom_range(int'(span), 0) : $urandom);
      apply_setting(step, limit, slices);

      steady = ($urandom_range(3, 0) == 0);
      repeat ($urandom_range(3, 1)) begin
        burst_len = $urandom_range(10, 1);
        broken    = ($urandom_range(7, 0) == 0);
        for (int i = 0; i < burst_len; i++)
          send_voxel(pick_cov(), pick_radius(), (i == burst_len - 1) && !broken);
      end
      if ($urandom_range(3, 0) == 0)
        send_voxel(COV_W'($urandom), RADIUS_W'($urandom), 1'($urandom_range(1, 0)));
      steady = 1'b0;
    end
    send_voxel(pick_cov(), pick_radius(), 1'b1);

    settle();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rch_pkg.sv
rtl/rch_front.sv
rtl/rch_queue.sv
rtl/rch_back.sv
rtl/radial_coverage_histogram.sv
bench/histogram_checker.sv
bench/tb_radial_coverage_histogram.sv
